@@ design/hcrd_pkg.sv @@
// Shared types and constants of the HTTP chunked response deframer.
`default_nettype none
package hcrd_pkg;

  localparam int unsigned TE_LEN  = 26;
  localparam int unsigned MAX_HEX = 8;

  localparam logic [8*TE_LEN-1:0] TE_TEXT = "transfer-encoding: chunked";

  // Parse phases
  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_SIZE  = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_CRLF  = 3'd3;
  localparam logic [2:0] PH_IDENT = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // Request codes on the input side
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [4:0]  LEN_SAT     = 5'd31;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
  localparam logic [15:0] COUNT_SAT   = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  phase;
    logic        pending_cr;
    logic [4:0]  line_length;
    logic        prefix_mismatch;
    logic        is_chunked;
    logic [31:0] size_accum;
    logic        size_line_bad;
    logic        extension_seen;
    logic [31:0] chunk_remaining;
    logic [15:0] body_count;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_HDR, pending_cr: 1'b0, line_length: 5'd0, prefix_mismatch: 1'b0,
    is_chunked: 1'b0, size_accum: 32'd0, size_line_bad: 1'b0,
    extension_seen: 1'b0, chunk_remaining: 32'd0, body_count: 16'd0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic       last;
    logic       chunked_mode;
  } res_t;

endpackage
`default_nettype wire

@@ design/hcrd_step.sv @@
// Next-state and result logic for one input word of the deframer.
`default_nettype none
module hcrd_step
  import hcrd_pkg::*;
(
  input  st_t         st,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic [15:0] body_limit,
  output st_t         st_nxt,
  output logic        res_valid,
  output res_t        res
);

  function automatic logic [7:0] te_char(input logic [4:0] idx);
    logic [7:0] c;
    c = 8'd0;
    for (int i = 0; i < TE_LEN; i++) begin
      if (idx == 5'(i)) begin
        c = TE_TEXT[8*(TE_LEN-1-i) +: 8];
      end
    end
    return c;
  endfunction

  // Adds one ordinary byte to the current line (header or size line).
  function automatic st_t line_content(input st_t s_in, input logic [7:0] b);
    st_t        s;
    logic [7:0] c;
    logic [3:0] nib;
    logic       is_hex;
    s      = s_in;
    c      = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    nib    = 4'd0;
    is_hex = 1'b0;
    if (b >= "0" && b <= "9") begin
      is_hex = 1'b1;
      nib    = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      is_hex = 1'b1;
      nib    = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      is_hex = 1'b1;
      nib    = 4'(b - "A" + 8'd10);
    end
    if (s.phase == PH_HDR) begin
      if (s.line_length < 5'(TE_LEN) && c != te_char(s.line_length)) begin
        s.prefix_mismatch = 1'b1;
      end
    end else if (!s.extension_seen && !s.size_line_bad) begin
      if (is_hex) begin
        s.size_accum = {s.size_accum[27:0], nib};
      end else if (b == ";") begin
        s.extension_seen = 1'b1;
      end else begin
        s.size_line_bad = 1'b1;
      end
    end
    if (s.line_length != LEN_SAT) begin
      s.line_length = s.line_length + 5'd1;
    end
    return s;
  endfunction

  function automatic st_t clear_line(input st_t s_in);
    st_t s;
    s                 = s_in;
    s.line_length     = 5'd0;
    s.prefix_mismatch = 1'b0;
    s.size_accum      = 32'd0;
    s.size_line_bad   = 1'b0;
    s.extension_seen  = 1'b0;
    return s;
  endfunction

  st_t         s;
  st_t         sl;
  logic        eol;
  logic [15:0] lim;
  logic [15:0] cnt_inc;
  logic        dlv_last;

  always_comb begin
    s         = st;
    sl        = st;
    eol       = 1'b0;
    res_valid = 1'b0;
    res       = '{kind: KIND_BYTE, body_byte: 8'd0, last: 1'b0,
                  chunked_mode: st.is_chunked};

    // Line assembly: a CR held back is either half of CR LF or a plain byte.
    if (st.pending_cr) begin
      sl.pending_cr = 1'b0;
      if (data_byte == 8'h0A) begin
        eol = 1'b1;
      end else begin
        sl = line_content(sl, 8'h0D);
      end
    end
    if (!eol) begin
      if (data_byte == 8'h0D) begin
        sl.pending_cr = 1'b1;
      end else begin
        sl = line_content(sl, data_byte);
      end
    end

    lim      = (body_limit == 16'd0) ? 16'd1 : body_limit;
    cnt_inc  = (st.body_count != COUNT_SAT) ? st.body_count + 16'd1 : st.body_count;
    dlv_last = (cnt_inc >= lim);

    case (req_type)
      REQ_BYTE: begin
        case (st.phase)
          PH_HDR: begin
            s = sl;
            if (eol) begin
              if (sl.line_length == 5'd0) begin
                s.phase = st.is_chunked ? PH_SIZE : PH_IDENT;
              end else if (sl.line_length >= 5'(TE_LEN) && !sl.prefix_mismatch) begin
                s.is_chunked = 1'b1;
              end
              s = clear_line(s);
            end
          end
          PH_SIZE: begin
            s = sl;
            if (eol) begin
              s = clear_line(s);
              if (sl.line_length == 5'd0 || sl.line_length > 5'(MAX_HEX) ||
                  sl.size_line_bad) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERR;
                res.last  = 1'b1;
              end else if (sl.size_accum == 32'd0) begin
                res_valid = 1'b1;
                res.kind  = KIND_END;
                res.last  = 1'b1;
              end else begin
                s.chunk_remaining = sl.size_accum;
                s.phase           = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            s.chunk_remaining = st.chunk_remaining - 32'd1;
            if (st.chunk_remaining == 32'd1) begin
              s.phase      = PH_CRLF;
              s.pending_cr = 1'b0;
            end
            s.body_count  = cnt_inc;
            res_valid     = 1'b1;
            res.body_byte = data_byte;
            res.last      = dlv_last;
          end
          PH_CRLF: begin
            if (!st.pending_cr) begin
              if (data_byte != 8'h0D) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERR;
                res.last  = 1'b1;
              end else begin
                s.pending_cr = 1'b1;
              end
            end else begin
              s.pending_cr = 1'b0;
              if (data_byte != 8'h0A) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERR;
                res.last  = 1'b1;
              end else begin
                s.phase = PH_SIZE;
                s       = clear_line(s);
              end
            end
          end
          PH_IDENT: begin
            s.body_count  = cnt_inc;
            res_valid     = 1'b1;
            res.body_byte = data_byte;
            res.last      = dlv_last;
          end
          default: begin
          end
        endcase
      end
      REQ_CLOSE: begin
        if (st.phase != PH_DONE) begin
          res_valid = 1'b1;
          res.kind  = (st.phase == PH_IDENT) ? KIND_END : KIND_ERR;
          res.last  = 1'b1;
        end
      end
      REQ_START: begin
        s = ST_RESET;
      end
      default: begin
      end
    endcase

    if (res_valid && res.last) begin
      s.phase = PH_DONE;
    end
    st_nxt = s;
  end

endmodule
`default_nettype wire

@@ design/http_chunked_response_deframer_unit.sv @@
// Top level of the HTTP/1.1 chunked response deframer.
//
//   Channel  Direction  Contents
//   in_      slave      tuser = req_type, tdata = data_byte
//   out_     master     tuser = kind, chunked_mode; tdata = body_byte; tlast = last
//   cfg_     write-only body_limit
//
// One word is taken per clock cycle while the output does not stall; each word yields
// zero or one result word, held first in the input register and then in the result
// register around the combinational parse step. rst_n is synchronous and active low;
// it clears the parse state, empties both registers and sets body_limit to 65535.
// A stall on the output holds the result register, and the input register then
// stops too, so in_tready falls only while both are full.
`default_nettype none
module http_chunked_response_deframer_unit
  import hcrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] body_byte
  output logic [2:0]       out_tuser,  // [1:0] kind, [2] chunked_mode
  output logic             out_tlast,  // last
  // Configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata   // body_limit
);

  // Input register
  logic       in_v_r;
  logic [1:0] in_req_r;
  logic [7:0] in_byte_r;

  // Parse state and limit register
  st_t         st_r;
  st_t         st_nxt;
  logic [15:0] limit_r;

  // Result register
  logic out_v_r;
  res_t out_res_r;

  logic step_valid;
  res_t step_res;
  logic advance;

  // The word in the input register is processed when the result register can
  // take whatever it yields: it is empty or is being read this cycle.
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  hcrd_step u_step (
    .st         (st_r),
    .req_type   (in_req_r),
    .data_byte  (in_byte_r),
    .body_limit (limit_r),
    .st_nxt     (st_nxt),
    .res_valid  (step_valid),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= ST_RESET;
      limit_r <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      // A word that yields nothing leaves an empty slot once the old result has gone.
      if (advance) begin
        out_v_r <= step_valid;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
    if (advance && step_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_res_r.body_byte;
  assign out_tuser  = {out_res_r.chunked_mode, out_res_r.kind};
  assign out_tlast  = out_res_r.last;

endmodule
`default_nettype wire
